// File: hdl/gasc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gasc_pkg: shared types and constants
// Control state encoding and fixed constants of the gait smoothing block.
// ----------------------------------------------------------------------------
package gasc_pkg;

   localparam int unsigned ANGLE_W       = 9;
   localparam logic [8:0]  ANGLE_MAX     = 9'd511;
   localparam logic [8:0]  KNEE_MIN_INIT = 9'd180;
   localparam logic [9:0]  AVG_MIN_INIT  = 10'd400;
   localparam logic [8:0]  CHANGE_RESET  = 9'd10;
   localparam logic [8:0]  MARGIN_RESET  = 9'd10;

   localparam logic CSR_MAX_CHANGE   = 1'b0;
   localparam logic CSR_PHASE_MARGIN = 1'b1;

   localparam logic [1:0] PH_NONE = 2'd0;
   localparam logic [1:0] PH_HS   = 2'd1;
   localparam logic [1:0] PH_TO   = 2'd2;
   localparam logic [1:0] PH_FF   = 2'd3;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SM_RD,
      ST_SM_WAIT,
      ST_SM_EVAL,
      ST_AV_RD,
      ST_AV_WAIT,
      ST_AV_ACC,
      ST_AV_DIV,
      ST_EX_RD,
      ST_EX_WAIT,
      ST_EX_ACC,
      ST_OUT_RD,
      ST_OUT_WAIT,
      ST_OUT_HOLD
   } state_type;

endpackage

// File: hdl/gasc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gasc_ram: generic single-port RAM
// One access per cycle, read data registered (a write cycle reads the old word).
// ----------------------------------------------------------------------------
module gasc_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

// File: hdl/gait_angle_smooth_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gait_angle_smooth_classify: gait angle smoothing and phase classification
// Stores ankle frames, suppresses spikes, averages blocks, labels phases.
// ----------------------------------------------------------------------------
// Loading accepts one frame beat per cycle. After the final frame the block
// smooths the stored frames over SMOOTH_PASSES passes, sums each block of
// frames and divides the sums by restoring steps, finds the extremes of the
// averages, then sends one result beat per frame, each after a read of the
// average memory and held until the receiver takes it. The sequencer reads
// one memory entry per step. Reset is synchronous and active high, resets the
// state, frame count, knee extremes and CSR values.
module gait_angle_smooth_classify #(
   parameter int MAX_FRAMES    = 64,
   parameter int BLOCK_LEN     = 4,
   parameter int SMOOTH_PASSES = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // left_ankle[8:0], right_ankle[17:9], left_knee[26:18], right_knee[35:27]
   input  logic [39:0] req_tdata,
   input  logic        req_tlast,   // final_frame
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // frame_index[5:0], left_average[14:6], right_average[23:15],
   // left_phase[25:24], right_phase[27:26], left_knee_top[36:28],
   // left_knee_bottom[44:37], right_knee_top[53:45], right_knee_bottom[61:54]
   output logic [63:0] rsp_tdata,
   output logic        rsp_tlast,   // run_end
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [8:0]  csr_wdata
);

   localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CW = $clog2(MAX_FRAMES + 1);
   localparam int PW = (SMOOTH_PASSES > 1) ? $clog2(SMOOTH_PASSES) : 1;
   localparam int BW = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN + 1) : 1;
   localparam int SW = 9 + BW;

   gasc_pkg::state_type state_ff, state_in;

   logic [8:0]     max_change_ff, phase_margin_ff;
   logic [CW-1:0]  count_ff, count_in;
   logic [8:0]     lk_max_ff, lk_min_ff, rk_max_ff, rk_min_ff;
   logic [8:0]     lk_max_in, lk_min_in, rk_max_in, rk_min_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic [CW-1:0]  blk_ff, blk_in;
   logic [PW-1:0]  pass_ff, pass_in;
   logic [8:0]     lprev_ff, rprev_ff, lprev_in, rprev_in;
   logic [9:0]     lmin_ff, rmin_ff, lmin_in, rmin_in;
   logic [8:0]     lmax_ff, rmax_ff, lmax_in, rmax_in;
   logic [SW-1:0]  lsum_ff, rsum_ff, lsum_in, rsum_in;
   logic [BW-1:0]  bcnt_ff, bcnt_in;
   logic [SW-1:0]  lrem_ff, rrem_ff, lrem_in, rrem_in;
   logic [8:0]     lq_ff, rq_ff, lq_in, rq_in;
   logic [8:0]     lavg_ff, ravg_ff, lavg_in, ravg_in;

   logic           s_we;
   logic [AW-1:0]  s_addr;
   logic [8:0]     ls_wd, rs_wd, ls_rd, rs_rd;
   logic           a_we;
   logic [AW-1:0]  a_addr;
   logic [8:0]     la_rd, ra_rd;

   gasc_ram #(.WIDTH(9), .DEPTH(MAX_FRAMES)) u_lsamp (
      .clock(clock), .wr_en(s_we), .addr(s_addr), .wr_data(ls_wd), .rd_data(ls_rd));
   gasc_ram #(.WIDTH(9), .DEPTH(MAX_FRAMES)) u_rsamp (
      .clock(clock), .wr_en(s_we), .addr(s_addr), .wr_data(rs_wd), .rd_data(rs_rd));
   // Block averages are kept per frame so output reads stay one address.
   gasc_ram #(.WIDTH(9), .DEPTH(MAX_FRAMES)) u_lavg (
      .clock(clock), .wr_en(a_we), .addr(a_addr), .wr_data(lq_ff), .rd_data(la_rd));
   gasc_ram #(.WIDTH(9), .DEPTH(MAX_FRAMES)) u_ravg (
      .clock(clock), .wr_en(a_we), .addr(a_addr), .wr_data(rq_ff), .rd_data(ra_rd));

   // Spike check for one side: the previous smoothed sample and current one.
   function automatic logic [8:0] fix_sample(input logic [8:0] cur, input logic [8:0] prv,
                                             input logic [8:0] lim);
      logic signed [11:0] d;
      logic        [10:0] mag;
      logic signed [13:0] t;
      begin
         d   = $signed({3'b0, cur}) - $signed({3'b0, prv});
         mag = d[11] ? 11'(-d) : 11'(d);
         t   = $signed({5'b0, cur}) * 14'sd4 - $signed({{2{d[11]}}, d}) * 14'sd3;
         if (mag <= {2'b0, lim}) fix_sample = cur;
         else if (t < 0) fix_sample = '0;
         else if (t[13:2] > 12'd511) fix_sample = gasc_pkg::ANGLE_MAX;
         else fix_sample = t[10:2];
      end
   endfunction

   function automatic logic [1:0] phase_of(input logic [8:0] a, input logic [9:0] mn,
                                           input logic [8:0] mx, input logic [8:0] m);
      logic [10:0] dmax, dmin;
      logic [1:0]  ph;
      begin
         dmax = (mx >= a) ? 11'(mx - a) : 11'(a - mx);
         dmin = (mn >= {1'b0, a}) ? 11'(mn - {1'b0, a}) : 11'({1'b0, a} - mn);
         ph = gasc_pkg::PH_NONE;
         if (dmax <= {2'b0, m}) ph = gasc_pkg::PH_HS;
         if (dmin <= {2'b0, m}) ph = gasc_pkg::PH_TO;
         if ((11'(a) + 11'(m) < 11'(mx)) && (11'(a) > 11'(mn) + 11'(m))) ph = gasc_pkg::PH_FF;
         phase_of = ph;
      end
   endfunction

   logic           accept;
   logic [CW-1:0]  last_idx;
   logic [CW-1:0]  blk_end;
   logic [8:0]     lfix, rfix;

   assign accept    = req_tvalid && req_tready;
   assign last_idx  = count_ff - 1'b1;
   assign csr_ready = 1'b1;
   assign lfix      = fix_sample(ls_rd, lprev_ff, max_change_ff);
   assign rfix      = fix_sample(rs_rd, rprev_ff, max_change_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_change_ff   <= gasc_pkg::CHANGE_RESET;
         phase_margin_ff <= gasc_pkg::MARGIN_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            gasc_pkg::CSR_MAX_CHANGE:   max_change_ff   <= csr_wdata;
            gasc_pkg::CSR_PHASE_MARGIN: phase_margin_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= gasc_pkg::ST_LOAD;
         count_ff  <= '0;
         lk_max_ff <= '0;
         rk_max_ff <= '0;
         lk_min_ff <= gasc_pkg::KNEE_MIN_INIT;
         rk_min_ff <= gasc_pkg::KNEE_MIN_INIT;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         lk_max_ff <= lk_max_in;
         rk_max_ff <= rk_max_in;
         lk_min_ff <= lk_min_in;
         rk_min_ff <= rk_min_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;   pass_ff <= pass_in;
      blk_ff   <= blk_in;
      lprev_ff <= lprev_in; rprev_ff <= rprev_in;
      lmin_ff  <= lmin_in;  rmin_ff <= rmin_in;
      lmax_ff  <= lmax_in;  rmax_ff <= rmax_in;
      lsum_ff  <= lsum_in;  rsum_ff <= rsum_in;
      bcnt_ff  <= bcnt_in;
      lrem_ff  <= lrem_in;  rrem_ff <= rrem_in;
      lq_ff    <= lq_in;    rq_ff <= rq_in;
      lavg_ff  <= lavg_in;  ravg_ff <= ravg_in;
   end

   // blk_ff holds the first frame of the block being averaged; blk_end is the
   // index after its last frame (the final frame never joins an average).
   assign blk_end = blk_ff + CW'(BLOCK_LEN);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      lk_max_in = lk_max_ff; lk_min_in = lk_min_ff;
      rk_max_in = rk_max_ff; rk_min_in = rk_min_ff;
      idx_in = idx_ff; pass_in = pass_ff; blk_in = blk_ff;
      lprev_in = lprev_ff; rprev_in = rprev_ff;
      lmin_in = lmin_ff; rmin_in = rmin_ff; lmax_in = lmax_ff; rmax_in = rmax_ff;
      lsum_in = lsum_ff; rsum_in = rsum_ff; bcnt_in = bcnt_ff;
      lrem_in = lrem_ff; rrem_in = rrem_ff; lq_in = lq_ff; rq_in = rq_ff;
      lavg_in = lavg_ff; ravg_in = ravg_ff;
      s_we = 1'b0; s_addr = idx_ff[AW-1:0];
      ls_wd = req_tdata[8:0]; rs_wd = req_tdata[17:9];
      a_we = 1'b0; a_addr = idx_ff[AW-1:0];
      req_tready = 1'b0; rsp_tvalid = 1'b0;

      unique case (state_ff)
         gasc_pkg::ST_LOAD: begin
            req_tready = 1'b1;
            s_addr = count_ff[AW-1:0];
            if (accept) begin
               if (count_ff < CW'(MAX_FRAMES)) begin
                  s_we = 1'b1;
                  count_in = count_ff + 1'b1;
                  if (req_tdata[26:18] > lk_max_ff) lk_max_in = req_tdata[26:18];
                  if (req_tdata[26:18] < lk_min_ff) lk_min_in = req_tdata[26:18];
                  if (req_tdata[35:27] > rk_max_ff) rk_max_in = req_tdata[35:27];
                  if (req_tdata[35:27] < rk_min_ff) rk_min_in = req_tdata[35:27];
               end
               if (req_tlast) begin
                  state_in = gasc_pkg::ST_SM_RD;
                  idx_in = '0;
                  pass_in = '0;
               end
            end
         end
         // Smoothing: within a pass, frame i compares with the already
         // smoothed frame i-1; the delta store collapses to that one value.
         gasc_pkg::ST_SM_RD: begin
            state_in = gasc_pkg::ST_SM_WAIT;
         end
         gasc_pkg::ST_SM_WAIT: begin
            state_in = gasc_pkg::ST_SM_EVAL;
         end
         gasc_pkg::ST_SM_EVAL: begin
            if (idx_ff == '0 || idx_ff + 1'b1 >= count_in) begin
               lprev_in = ls_rd; rprev_in = rs_rd;
            end else begin
               s_we = 1'b1; ls_wd = lfix; rs_wd = rfix;
               lprev_in = lfix; rprev_in = rfix;
            end
            if (idx_ff + 1'b1 >= count_ff) begin
               idx_in = '0;
               if (pass_ff == PW'(SMOOTH_PASSES - 1)) begin
                  state_in = gasc_pkg::ST_AV_RD;
                  lsum_in = '0; rsum_in = '0; bcnt_in = '0;
                  blk_in = '0;
               end else begin
                  pass_in = pass_ff + 1'b1;
                  state_in = gasc_pkg::ST_SM_RD;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = gasc_pkg::ST_SM_RD;
            end
         end
         // Averages: accumulate each block, then divide by restoring steps.
         gasc_pkg::ST_AV_RD: begin
            state_in = gasc_pkg::ST_AV_WAIT;
         end
         gasc_pkg::ST_AV_WAIT: begin
            state_in = gasc_pkg::ST_AV_ACC;
         end
         gasc_pkg::ST_AV_ACC: begin
            if (idx_ff < last_idx) begin
               lsum_in = lsum_ff + SW'(ls_rd);
               rsum_in = rsum_ff + SW'(rs_rd);
               bcnt_in = bcnt_ff + 1'b1;
            end
            if (idx_ff + 1'b1 == blk_end || idx_ff == last_idx) begin
               if (idx_ff < last_idx || bcnt_ff != '0) begin
                  lrem_in = (idx_ff < last_idx) ? lsum_ff + SW'(ls_rd) : lsum_ff;
                  rrem_in = (idx_ff < last_idx) ? rsum_ff + SW'(rs_rd) : rsum_ff;
                  lq_in = '0; rq_in = '0;
                  lprev_in = 9'd8;
                  state_in = gasc_pkg::ST_AV_DIV;
               end else begin
                  // A block holding only the final frame takes its value and
                  // goes straight to writing.
                  lq_in = ls_rd; rq_in = rs_rd;
                  lprev_in = 9'h100;
                  rprev_in = 9'(blk_ff);
                  state_in = gasc_pkg::ST_AV_DIV;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = gasc_pkg::ST_AV_RD;
            end
         end
         gasc_pkg::ST_AV_DIV: begin
            // lprev_ff counts quotient bits; all ones marks a finished quotient,
            // then the block's frames are written with it via rprev as index.
            if (lprev_ff != 9'h1ff && lprev_ff[8:4] == '0) begin
               if ((lrem_ff >> lprev_ff[3:0]) >= SW'(bcnt_ff)) begin
                  lrem_in = lrem_ff - (SW'(bcnt_ff) << lprev_ff[3:0]);
                  lq_in[lprev_ff[3:0]] = 1'b1;
               end
               if ((rrem_ff >> lprev_ff[3:0]) >= SW'(bcnt_ff)) begin
                  rrem_in = rrem_ff - (SW'(bcnt_ff) << lprev_ff[3:0]);
                  rq_in[lprev_ff[3:0]] = 1'b1;
               end
               lprev_in = (lprev_ff == '0) ? 9'h1ff : lprev_ff - 1'b1;
               rprev_in = 9'(blk_ff);
            end else begin
               if (lprev_ff == 9'h1ff && rprev_ff[8] == 1'b0) begin
                  rprev_in = 9'(blk_ff);
                  lprev_in = 9'h100;
               end else begin
                  a_we = 1'b1;
                  a_addr = rprev_ff[AW-1:0];
                  rprev_in = rprev_ff + 1'b1;
                  if (CW'(rprev_ff) + 1'b1 >= blk_end || CW'(rprev_ff) >= last_idx) begin
                     lsum_in = '0; rsum_in = '0; bcnt_in = '0;
                     if (idx_ff >= last_idx) begin
                        idx_in = '0;
                        lmin_in = gasc_pkg::AVG_MIN_INIT; rmin_in = gasc_pkg::AVG_MIN_INIT;
                        lmax_in = '0; rmax_in = '0;
                        state_in = gasc_pkg::ST_EX_RD;
                     end else begin
                        idx_in = idx_ff + 1'b1;
                        blk_in = blk_end;
                        state_in = gasc_pkg::ST_AV_RD;
                     end
                  end
               end
            end
         end
         gasc_pkg::ST_EX_RD: begin
            state_in = gasc_pkg::ST_EX_WAIT;
         end
         gasc_pkg::ST_EX_WAIT: begin
            state_in = gasc_pkg::ST_EX_ACC;
         end
         gasc_pkg::ST_EX_ACC: begin
            if ({1'b0, la_rd} < lmin_ff) lmin_in = {1'b0, la_rd};
            if (la_rd > lmax_ff) lmax_in = la_rd;
            if ({1'b0, ra_rd} < rmin_ff) rmin_in = {1'b0, ra_rd};
            if (ra_rd > rmax_ff) rmax_in = ra_rd;
            if (idx_ff == last_idx) begin
               idx_in = '0;
               state_in = gasc_pkg::ST_OUT_RD;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = gasc_pkg::ST_EX_RD;
            end
         end
         gasc_pkg::ST_OUT_RD: begin
            state_in = gasc_pkg::ST_OUT_WAIT;
         end
         gasc_pkg::ST_OUT_WAIT: begin
            lavg_in = la_rd; ravg_in = ra_rd;
            state_in = gasc_pkg::ST_OUT_HOLD;
         end
         gasc_pkg::ST_OUT_HOLD: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (idx_ff == last_idx) begin
                  state_in = gasc_pkg::ST_LOAD;
                  count_in = '0;
                  lk_max_in = '0; rk_max_in = '0;
                  lk_min_in = gasc_pkg::KNEE_MIN_INIT;
                  rk_min_in = gasc_pkg::KNEE_MIN_INIT;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  state_in = gasc_pkg::ST_OUT_RD;
               end
            end
         end
         default: state_in = gasc_pkg::ST_LOAD;
      endcase
   end

   assign rsp_tdata = {2'b0, rk_min_ff[7:0], rk_max_ff, lk_min_ff[7:0], lk_max_ff,
                       phase_of(ravg_ff, rmin_ff, rmax_ff, phase_margin_ff),
                       phase_of(lavg_ff, lmin_ff, lmax_ff, phase_margin_ff),
                       ravg_ff, lavg_ff, idx_ff[5:0]};
   assign rsp_tlast = (idx_ff == last_idx);

   a_no_rsp_in_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == gasc_pkg::ST_LOAD |-> !rsp_tvalid) else $error("result during load");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_FRAMES)) else $error("frame count overflow");
   a_clear_after_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> count_ff == '0) else $error("no clear");

endmodule
